>>> design/exgb_pkg.sv
// ----------------------------------------------------------------------------
// exgb_pkg
// shared types and constants of the exp-golomb bit reader
// ----------------------------------------------------------------------------
package exgb_pkg;

  localparam int unsigned DEF_BUFFER_BYTES = 4096;
  localparam int unsigned MAX_PREFIX_ZEROS = 32;
  localparam int unsigned ZW               = 6;   // prefix zero count, up to 32
  localparam int unsigned VW               = 32;  // result width

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_FIXED = 2'd1,
    KIND_UE    = 2'd2,
    KIND_SE    = 2'd3
  } kind_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // append the input byte
    logic start;     // latch a read item
    logic rd;        // read the byte under the bit position
    logic pre_step;  // count prefix zeros in the fetched byte
    logic suf_step;  // shift bits of the fetched byte into the accumulator
    logic sum;       // form the code from prefix and suffix
    logic emit;      // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic err;       // sticky error flag
    logic pre_end;   // prefix ends in this step
    logic pre_zero;  // prefix ended with no zeros
    logic suf_end;   // suffix or fixed field ends in this step
    logic out_free;  // output register can take a result
  } status_t;

endpackage

>>> design/exgb_if.sv
// ----------------------------------------------------------------------------
// exgb channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface exgb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       start_new;
  logic [5:0] read_width;

  modport source (output valid, kind, data_byte, start_new, read_width, input ready);
  modport sink   (input valid, kind, data_byte, start_new, read_width, output ready);
endinterface

interface exgb_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] value;
  logic signed [31:0] signed_value;
  logic               error;

  modport source (output valid, value, signed_value, error, input ready);
  modport sink   (input valid, value, signed_value, error, output ready);
endinterface

>>> design/exgb_ctrl.sv
// ----------------------------------------------------------------------------
// exgb_ctrl
// sequencer: fetch/extract steps over prefix and suffix, then sum and emit
// ----------------------------------------------------------------------------
module exgb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       kind_i,
  input  logic [5:0]       read_width_i,
  input  exgb_pkg::status_t status_i,
  output logic             in_ready_o,
  output exgb_pkg::cmd_t   cmd_o
);
  import exgb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PRE_RD, S_PRE_EX, S_SUF_RD, S_SUF_EX, S_SUM, S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == S_IDLE);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          if (kind_i == KIND_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            if (kind_i == KIND_FIXED) begin
              state_d = (read_width_i == '0) ? S_SUM : S_SUF_RD;
            end else begin
              // no prefix is counted while the error flag is set
              state_d = status_i.err ? S_SUM : S_PRE_RD;
            end
          end
        end
      end
      S_PRE_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_PRE_EX;
      end
      S_PRE_EX: begin
        cmd_o.pre_step = 1'b1;
        if (status_i.pre_end) begin
          state_d = status_i.pre_zero ? S_SUM : S_SUF_RD;
        end else begin
          state_d = S_PRE_RD;
        end
      end
      S_SUF_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_SUF_EX;
      end
      S_SUF_EX: begin
        cmd_o.suf_step = 1'b1;
        state_d = status_i.suf_end ? S_SUM : S_SUF_RD;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/exgb_dp.sv
// ----------------------------------------------------------------------------
// exgb_dp
// byte store, bit position, prefix counter, bit accumulator, output register
// ----------------------------------------------------------------------------
module exgb_dp #(
  parameter int unsigned BUFFER_BYTES = exgb_pkg::DEF_BUFFER_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  exgb_pkg::cmd_t     cmd_i,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         data_byte_i,
  input  logic               start_new_i,
  input  logic [5:0]         read_width_i,
  input  logic               out_ready_i,
  output exgb_pkg::status_t  status_o,
  output logic               out_valid_o,
  output logic [31:0]        value_o,
  output logic signed [31:0] signed_value_o,
  output logic               error_o
);
  import exgb_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned PW = CW + 3;

  logic [7:0]    store_q [BUFFER_BYTES];
  logic [7:0]    rd_data_q;

  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          err_q, err_d;
  logic [ZW-1:0] zeros_q, zeros_d;
  logic [ZW-1:0] rem_q, rem_d;
  logic [VW-1:0] acc_q, acc_d;
  logic [1:0]    kind_q;
  logic [VW-1:0] code_q;

  logic          out_valid_q;
  logic [VW-1:0] out_value_q, out_sval_q;
  logic          out_err_q;

  // load path
  logic [CW-1:0] load_cnt;
  logic          load_we;

  // byte window
  logic [CW-1:0] idx;
  logic          overrun;
  logic [2:0]    off;
  logic [3:0]    avail;
  logic [7:0]    win;
  logic [3:0]    lz, lz_eff;
  logic [ZW-1:0] lim;
  logic [3:0]    n;
  logic [7:0]    chunk;

  // result mapping
  logic [VW-1:0] code_inc, sval;

  assign load_cnt = start_new_i ? '0 : count_q;
  assign load_we  = cmd_i.load && (load_cnt < CW'(BUFFER_BYTES));

  assign idx     = pos_q[PW-1:3];
  assign overrun = (idx >= count_q);
  assign off     = pos_q[2:0];
  assign avail   = 4'd8 - {1'b0, off};
  assign win     = rd_data_q << off;
  assign lim     = ZW'(MAX_PREFIX_ZEROS) - zeros_q;

  always_comb begin
    lz = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (win[i]) lz = 4'(7 - i);
    end
  end

  assign lz_eff = (lz > avail) ? avail : lz;
  assign n      = ({2'b00, avail} < rem_q) ? avail : rem_q[3:0];
  assign chunk  = win >> (4'd8 - n);

  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    err_d   = err_q;
    zeros_d = zeros_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    status_o.err      = err_q;
    status_o.pre_end  = 1'b0;
    status_o.suf_end  = 1'b0;
    status_o.out_free = !out_valid_q || out_ready_i;

    if (cmd_i.load) begin
      if (start_new_i) begin
        pos_d = '0;
        err_d = 1'b0;
      end
      count_d = load_we ? load_cnt + CW'(1) : load_cnt;
    end

    if (cmd_i.start) begin
      zeros_d = '0;
      acc_d   = '0;
      rem_d   = (read_width_i > 6'd32) ? 6'd32 : read_width_i;
    end

    if (cmd_i.pre_step) begin
      status_o.pre_end = 1'b1;
      if (overrun) begin
        // the overrunning bit still counts as a zero
        zeros_d = zeros_q + ZW'(1);
        err_d   = 1'b1;
      end else if ({2'b00, lz_eff} >= lim) begin
        zeros_d = ZW'(MAX_PREFIX_ZEROS);
        pos_d   = pos_q + PW'(lim);
      end else if (lz_eff < avail) begin
        zeros_d = zeros_q + ZW'(lz_eff);
        pos_d   = pos_q + PW'(lz_eff) + PW'(1);
      end else begin
        zeros_d = zeros_q + ZW'(avail);
        pos_d   = pos_q + PW'(avail);
        status_o.pre_end = 1'b0;
      end
      rem_d = zeros_d;
    end

    if (cmd_i.suf_step) begin
      status_o.suf_end = 1'b1;
      if (overrun) begin
        err_d = 1'b1;
      end else begin
        acc_d = (acc_q << n) | VW'(chunk);
        pos_d = pos_q + PW'(n);
        rem_d = rem_q - ZW'(n);
        status_o.suf_end = (rem_q == ZW'(n));
      end
    end

    status_o.pre_zero = (zeros_d == '0);
  end

  assign code_inc = code_q + VW'(1);
  assign sval     = code_q[0] ? {1'b0, code_inc[VW-1:1]} : (VW'(0) - {1'b0, code_q[VW-1:1]});

  // byte store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      store_q[load_cnt[AW-1:0]] <= data_byte_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= store_q[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pos_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
      err_q   <= err_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    zeros_q <= zeros_d;
    rem_q   <= rem_d;
    acc_q   <= acc_d;
    if (cmd_i.start) begin
      kind_q <= kind_i;
    end
    if (cmd_i.sum) begin
      // 2^zeros - 1 is a low mask, all ones for 32 zeros
      code_q <= ~({VW{1'b1}} << zeros_q) + acc_q;
    end
    if (cmd_i.emit) begin
      out_value_q <= (kind_q == KIND_SE) ? '0 : code_q;
      out_sval_q  <= (kind_q == KIND_SE) ? sval : '0;
      out_err_q   <= err_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = out_value_q;
  assign signed_value_o = $signed(out_sval_q);
  assign error_o        = out_err_q;

endmodule

>>> design/exp_golomb_bit_reader_unit.sv
// ----------------------------------------------------------------------------
// exp_golomb_bit_reader_unit
// byte-buffered msb-first bit reader with fixed-width and exp-golomb reads
// ----------------------------------------------------------------------------
// A load item appends its byte to the store (BUFFER_BYTES deep); with
// start_new it first clears the count, the bit position and the sticky error,
// and a load into a full store is dropped. A read item walks the store one
// byte per step: every byte touched takes a registered memory read, then
// extraction of up to eight bits or a leading-zero count in that byte. Around
// these steps the item is accepted, the code is formed and the output
// register is loaded once it is free. The store's single read port is why
// every byte needs its own read step. Zero-width reads and exp-golomb reads
// while the error flag is set skip the byte steps. Results wait in an output
// register, so the next item is accepted while one is pending. A read past
// the stored bytes sets the sticky error and returns the bits gathered so
// far; exp-golomb prefixes stop at 32 zeros and codes wrap at 2^32. There is
// no clearing pass: store entries are valid once written.
// ----------------------------------------------------------------------------
module exp_golomb_bit_reader_unit #(
  parameter int unsigned BUFFER_BYTES = exgb_pkg::DEF_BUFFER_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  exgb_in_if.sink     in_i,
  exgb_out_if.source  out_o
);
  import exgb_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: one item at a time
  exgb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .kind_i       (in_i.kind),
    .read_width_i (in_i.read_width),
    .status_i     (status),
    .in_ready_o   (in_i.ready),
    .cmd_o        (cmd)
  );

  // store, position, accumulator and output register
  exgb_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (in_i.kind),
    .data_byte_i    (in_i.data_byte),
    .start_new_i    (in_i.start_new),
    .read_width_i   (in_i.read_width),
    .out_ready_i    (out_o.ready),
    .status_o       (status),
    .out_valid_o    (out_o.valid),
    .value_o        (out_o.value),
    .signed_value_o (out_o.signed_value),
    .error_o        (out_o.error)
  );

  // a read transfer hands control to the sequencer
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.kind != KIND_LOAD) |=> !in_i.ready)
    else $error("input still ready after a read transfer");

  // a load completes in the cycle it is taken
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.kind == KIND_LOAD) |=> in_i.ready)
    else $error("input not ready after a load transfer");

  // a result is never written over a pending one
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("result emitted into a busy output register");

  // an emitted result shows on the output channel
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_o.valid)
    else $error("emitted result not presented");

endmodule

>>> tb/sv/tb_exp_golomb_bit_reader_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_exp_golomb_bit_reader_unit
// self-checking bench for the exp-golomb bit reader: a queue-fed driver sends
// load and read items, a shadow reader predicts every result and a monitor
// compares each result transfer field by field, with random gaps on both sides
// ----------------------------------------------------------------------------
module tb_exp_golomb_bit_reader_unit;
  import exgb_pkg::*;

  localparam int unsigned STORE_BYTES = DEF_BUFFER_BYTES;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned QUIET_LIMIT = 1000;  // cycles with no transfer at all
  localparam int unsigned DRAIN_CYCLES = 64;   // quiet margin after the last due result
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    kind_e      kind;
    logic [7:0] data_byte;
    logic       start_new;
    logic [5:0] read_width;
  } reader_item_t;

  typedef struct {
    logic        [31:0] value;
    logic signed [31:0] signed_value;
    logic               error;
  } reader_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  exgb_in_if  in_ch ();
  exgb_out_if out_ch ();

  exp_golomb_bit_reader_unit #(
    .BUFFER_BYTES(STORE_BYTES)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // stimulus and expectations
  reader_item_t   stream_q[$];
  reader_result_t due_q[$];
  reader_item_t   cur_item;
  reader_result_t want;

  // shadow copy of the reader state
  logic [7:0]  shadow_store [STORE_BYTES];
  int unsigned shadow_count = 0;
  int unsigned shadow_pos = 0;
  bit          shadow_err = 1'b0;

  int unsigned total_items = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          send_calm = 1'b0;
  bit          take_calm = 1'b0;

  // --------------------------------------------------------------------------
  // shadow reader
  // --------------------------------------------------------------------------

  // msb-first bit fetch; stops at the first bit past the stored bytes
  function automatic logic [31:0] take_bits(int unsigned width);
    logic [31:0] acc;
    logic [7:0]  byte_now;
    int unsigned left;
    int unsigned idx;
    acc = '0;
    left = (width > 32) ? 32 : width;
    while (left > 0) begin
      idx = shadow_pos >> 3;
      if (idx >= shadow_count || idx >= STORE_BYTES) begin
        shadow_err = 1'b1;
        return acc;
      end
      byte_now = shadow_store[idx] >> (7 - (shadow_pos & 7));
      acc = {acc[30:0], byte_now[0]};
      shadow_pos++;
      left--;
    end
    return acc;
  endfunction

  // unsigned exp-golomb code, wrapping at 2^32
  function automatic logic [31:0] take_ue_code();
    int unsigned zeros;
    logic [63:0] sum;
    zeros = 0;
    // no prefix counting while the sticky error is up; an overrunning
    // prefix bit still counts as a zero
    forever begin
      if (zeros >= MAX_PREFIX_ZEROS || shadow_err) break;
      if (take_bits(1) != 32'd0) break;
      zeros++;
    end
    if (zeros == 0) return 32'd0;
    sum = (64'd1 << zeros) - 64'd1;
    sum = sum + {32'd0, take_bits(zeros)};
    return sum[31:0];
  endfunction

  // applies one accepted item and queues the result it is due to produce
  function automatic void advance_reader(reader_item_t it);
    reader_result_t res;
    logic [31:0]    code;
    logic [31:0]    bumped;
    res.value = '0;
    res.signed_value = '0;
    case (it.kind)
      KIND_LOAD: begin
        if (it.start_new) begin
          shadow_count = 0;
          shadow_pos = 0;
          shadow_err = 1'b0;
        end
        // a full store drops the byte
        if (shadow_count < STORE_BYTES) begin
          shadow_store[shadow_count] = it.data_byte;
          shadow_count++;
        end
        return;
      end
      KIND_FIXED: begin
        res.value = take_bits(it.read_width);
      end
      KIND_UE: begin
        res.value = take_ue_code();
      end
      default: begin
        code = take_ue_code();
        if (code[0]) begin
          bumped = code + 32'd1;
          res.signed_value = bumped >> 1;
        end else begin
          res.signed_value = 32'd0 - (code >> 1);
        end
      end
    endcase
    res.error = shadow_err;
    due_q.push_back(res);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void push_load(bit fresh, logic [7:0] b);
    reader_item_t it;
    it.kind = KIND_LOAD;
    it.data_byte = b;
    it.start_new = fresh;
    it.read_width = 6'($urandom_range(0, 63));
    stream_q.push_back(it);
  endfunction

  // data_byte and start_new are don't-care on reads, so they carry noise
  function automatic void push_read(kind_e k, logic [5:0] w);
    reader_item_t it;
    it.kind = k;
    it.data_byte = 8'($urandom_range(0, 255));
    it.start_new = 1'($urandom_range(0, 1));
    it.read_width = w;
    stream_q.push_back(it);
  endfunction

  // zero bytes make long prefixes, all-ones bytes make short codes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(1, 15));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [5:0] pick_width();
    case ($urandom_range(0, 15))
      0:       return 6'd0;
      1:       return 6'($urandom_range(33, 63));
      2:       return 6'd32;
      default: return 6'($urandom_range(1, 31));
    endcase
  endfunction

  // per-item wait, with calm stretches where no idling happens
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic void build_directed();
    // read from an empty store overruns, then a ue read with error set
    push_read(KIND_FIXED, 6'd8);
    push_read(KIND_UE, 6'd0);
    // 32 zeros then 32 ones: longest prefix, sum wraps
    push_load(1'b1, 8'h00);
    repeat (3) push_load(1'b0, 8'h00);
    repeat (4) push_load(1'b0, 8'hFF);
    push_read(KIND_UE, 6'd0);
    push_load(1'b0, 8'hA5);
    push_load(1'b0, 8'h3C);
    push_load(1'b0, 8'h5A);
    push_load(1'b0, 8'hC3);
    // zero-width read, then a wide read clamped to 32 bits
    push_read(KIND_FIXED, 6'd0);
    push_read(KIND_FIXED, 6'd63);
    // fresh buffer restarts the store; se code 011 maps to -1
    push_load(1'b1, 8'h6F);
    push_read(KIND_SE, 6'd0);
    push_read(KIND_FIXED, 6'd1);
    // partial field at the end of the store
    push_read(KIND_FIXED, 6'd32);
    // ue takes the leading 1; se prefix then overruns, the overrunning bit counts
    push_load(1'b1, 8'h80);
    push_read(KIND_UE, 6'd0);
    push_read(KIND_SE, 6'd0);
  endfunction

  function automatic void build_random();
    int unsigned made;
    int unsigned len;
    int unsigned reads;
    made = 0;
    while (made < RANDOM_ITEMS) begin
      // a buffer, now and then appended to the old one instead
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 16);
      for (int unsigned i = 0; i < len; i++) begin
        push_load(i == 0 && $urandom_range(0, 7) != 0, pick_byte());
        made++;
      end
      reads = $urandom_range(1, 14);
      for (int unsigned j = 0; j < reads; j++) begin
        case ($urandom_range(0, 39))
          0:       push_load(1'b1, pick_byte());
          1, 2, 3: push_load(1'b0, pick_byte());
          default: push_read(kind_e'($urandom_range(1, 3)), pick_width());
        endcase
        made++;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset and run control
  // --------------------------------------------------------------------------

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    // known input levels from time zero
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.data_byte = '0;
    in_ch.start_new = 1'b0;
    in_ch.read_width = '0;
    out_ch.ready = 1'b0;

    build_directed();
    build_random();
    total_items = stream_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // all items accepted and every due result delivered
    while (items_sent < total_items || due_q.size() != 0) @(posedge clk);
    // catch stray results after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // driver: one item in flight on the input channel
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      // transfer at this edge: the shadow reader takes the item
      if (in_ch.valid && in_ch.ready) begin
        advance_reader(cur_item);
        items_sent++;
      end
      // channel free: idle out the gap or present the next item
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 || stream_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_ch.valid <= 1'b0;
        end else begin
          cur_item = stream_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.kind <= cur_item.kind;
          in_ch.data_byte <= cur_item.data_byte;
          in_ch.start_new <= cur_item.start_new;
          in_ch.read_width <= cur_item.read_width;
          gap_left = draw_wait(send_calm);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: result checks and receiver back-pressure
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (due_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("result %0d arrived with nothing due: value %h signed %0d error %0b",
                     results_seen, out_ch.value, out_ch.signed_value, out_ch.error);
          end
        end else begin
          want = due_q.pop_front();
          if (out_ch.value !== want.value || out_ch.signed_value !== want.signed_value ||
              out_ch.error !== want.error) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("result %0d mismatch: value exp %h got %h, signed exp %0d got %0d, %s",
                       results_seen, want.value, out_ch.value, want.signed_value,
                       out_ch.signed_value,
                       $sformatf("error exp %0b got %0b", want.error, out_ch.error));
            end
          end
        end
        stall_left = draw_wait(take_calm);
      end
      // hold ready low for the drawn stall, then wait for the next result
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: ends a run that stops moving
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule

>>> sim.f
design/exgb_pkg.sv
design/exgb_if.sv
design/exgb_ctrl.sv
design/exgb_dp.sv
design/exp_golomb_bit_reader_unit.sv
tb/sv/tb_exp_golomb_bit_reader_unit.sv
